// ===== rtl/hpc_pkg.sv =====
package hpc_pkg;

  localparam int unsigned PosW        = 16;
  localparam int unsigned HdrW        = 6;
  localparam int unsigned PrefixDepth = 6;
  localparam int unsigned SeenW       = 3;

  localparam logic [PosW-1:0] EthHdrBytes  = 16'd14;
  localparam logic [PosW-1:0] EtypeHiPos   = 16'd12;
  localparam logic [PosW-1:0] EtypeLoPos   = 16'd13;
  localparam logic [PosW-1:0] IhlPos       = 16'd14;
  localparam logic [PosW-1:0] TlenHiPos    = 16'd16;
  localparam logic [PosW-1:0] TlenLoPos    = 16'd17;
  localparam logic [PosW-1:0] ProtoPos     = 16'd23;
  localparam logic [PosW-1:0] TcpOffsetPos = 16'd26;
  localparam logic [PosW-1:0] IpMinFrame   = 16'd24;
  localparam logic [PosW-1:0] TcpMinFrame  = 16'd27;
  localparam logic [PosW-1:0] PosMax       = 16'hFFFF;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp      = 8'd6;
  localparam logic [HdrW-1:0] MinHdrBytes = 6'd20;
  localparam logic [7:0]  MinPayloadReset = 8'd7;

  typedef enum logic [2:0] {
    MATCH_NONE   = 3'd0,
    MATCH_HTTP   = 3'd1,
    MATCH_GET    = 3'd2,
    MATCH_POST   = 3'd3,
    MATCH_PUT    = 3'd4,
    MATCH_DELETE = 3'd5,
    MATCH_HEAD   = 3'd6
  } match_kind_t;

  typedef enum logic [2:0] {
    DROP_NONE          = 3'd0,
    DROP_ETHERTYPE     = 3'd1,
    DROP_PROTOCOL      = 3'd2,
    DROP_SHORT_HEADER  = 3'd3,
    DROP_SHORT_PAYLOAD = 3'd4,
    DROP_NO_MATCH      = 3'd5,
    DROP_TRUNCATED     = 3'd6
  } drop_reason_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctrl_t;

  typedef struct packed {
    logic         keep;
    match_kind_t  kind;
    drop_reason_t reason;
  } verdict_t;

endpackage

// ===== rtl/hpc_in_stage.sv =====
module hpc_in_stage import hpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        advance,
  output logic        in_stall,
  output stage_ctrl_t stage,
  output logic [7:0]  stage_byte
);

  logic accept;

  assign in_stall = stage.valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= accept || (stage.valid && !advance);
    end
    if (accept) begin
      stage_byte <= data_byte;
      stage.last <= last_byte;
    end
  end

endmodule

// ===== rtl/hpc_frame_parser.sv =====
module hpc_frame_parser import hpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic [7:0] min_payload_length,
  output verdict_t   verdict
);

  logic [PosW-1:0]  pos, pos_next;
  logic [15:0]      ether_type, ether_type_next;
  logic [7:0]       protocol, protocol_next;
  logic [HdrW-1:0]  ip_hdr, ip_hdr_next;
  logic [15:0]      total_len, total_len_next;
  logic [HdrW-1:0]  tcp_hdr, tcp_hdr_next;
  logic [SeenW-1:0] seen, seen_next;
  logic [7:0]       prefix [PrefixDepth];
  logic [7:0]       prefix_next [PrefixDepth];
  logic             prefix_we;

  logic [PosW-1:0]  tcp_pos;
  logic [PosW-1:0]  start_pos;
  logic [PosW-1:0]  rel_pos;
  logic [HdrW:0]    hdrs;
  logic [15:0]      plen;
  logic             m_http, m_get, m_post, m_put, m_delete, m_head;

  assign tcp_pos   = TcpOffsetPos + PosW'(ip_hdr);
  assign start_pos = EthHdrBytes + PosW'(ip_hdr) + PosW'(tcp_hdr);
  assign rel_pos   = pos - start_pos;

  always_comb begin
    ether_type_next = ether_type;
    protocol_next   = protocol;
    ip_hdr_next     = ip_hdr;
    total_len_next  = total_len;
    tcp_hdr_next    = tcp_hdr;
    seen_next       = seen;
    prefix_we       = 1'b0;
    for (int i = 0; i < PrefixDepth; i++) begin
      prefix_next[i] = prefix[i];
    end

    case (pos)
      EtypeHiPos: ether_type_next = {data_byte, 8'h00};
      EtypeLoPos: ether_type_next = ether_type | {8'h00, data_byte};
      IhlPos:     ip_hdr_next     = {data_byte[3:0], 2'b00};
      TlenHiPos:  total_len_next  = {data_byte, 8'h00};
      TlenLoPos:  total_len_next  = total_len | {8'h00, data_byte};
      ProtoPos:   protocol_next   = data_byte;
      default: ;
    endcase

    if (pos >= TcpOffsetPos && pos == tcp_pos) begin
      tcp_hdr_next = {data_byte[7:4], 2'b00};
    end else if (pos > tcp_pos && pos >= start_pos &&
                 rel_pos < PosW'(PrefixDepth) && seen < SeenW'(PrefixDepth)) begin
      prefix_we         = 1'b1;
      prefix_next[seen] = data_byte;
      seen_next         = seen + 1'b1;
    end

    pos_next = (pos == PosMax) ? pos : pos + 1'b1;
  end

  // pattern hits on the frame state including the current byte
  assign m_http   = seen_next >= 3'd4 && prefix_next[0] == "H" && prefix_next[1] == "T"
                    && prefix_next[2] == "T" && prefix_next[3] == "P";
  assign m_get    = seen_next >= 3'd3 && prefix_next[0] == "G" && prefix_next[1] == "E"
                    && prefix_next[2] == "T";
  assign m_post   = seen_next >= 3'd4 && prefix_next[0] == "P" && prefix_next[1] == "O"
                    && prefix_next[2] == "S" && prefix_next[3] == "T";
  assign m_put    = seen_next >= 3'd3 && prefix_next[0] == "P" && prefix_next[1] == "U"
                    && prefix_next[2] == "T";
  assign m_delete = seen_next >= 3'd6 && prefix_next[0] == "D" && prefix_next[1] == "E"
                    && prefix_next[2] == "L" && prefix_next[3] == "E"
                    && prefix_next[4] == "T" && prefix_next[5] == "E";
  assign m_head   = seen_next >= 3'd4 && prefix_next[0] == "H" && prefix_next[1] == "E"
                    && prefix_next[2] == "A" && prefix_next[3] == "D";

  assign hdrs = {1'b0, ip_hdr_next} + {1'b0, tcp_hdr_next};
  assign plen = total_len_next - 16'(hdrs);

  always_comb begin
    verdict.kind   = MATCH_NONE;
    verdict.reason = DROP_NONE;
    if (pos_next < EthHdrBytes) begin
      verdict.reason = DROP_TRUNCATED;
    end else if (ether_type_next != EtherTypeIpv4) begin
      verdict.reason = DROP_ETHERTYPE;
    end else if (pos_next < IpMinFrame) begin
      verdict.reason = DROP_TRUNCATED;
    end else if (protocol_next != ProtoTcp) begin
      verdict.reason = DROP_PROTOCOL;
    end else if (ip_hdr_next < MinHdrBytes) begin
      verdict.reason = DROP_SHORT_HEADER;
    end else if (pos_next < TcpMinFrame + PosW'(ip_hdr_next)) begin
      verdict.reason = DROP_TRUNCATED;
    end else if (tcp_hdr_next < MinHdrBytes) begin
      verdict.reason = DROP_SHORT_HEADER;
    end else if (total_len_next < 16'(hdrs)) begin
      verdict.reason = DROP_SHORT_PAYLOAD;
    end else if (plen < 16'(min_payload_length)) begin
      verdict.reason = DROP_SHORT_PAYLOAD;
    end else if (m_http) begin
      verdict.kind = MATCH_HTTP;
    end else if (m_get) begin
      verdict.kind = MATCH_GET;
    end else if (m_post) begin
      verdict.kind = MATCH_POST;
    end else if (m_put) begin
      verdict.kind = MATCH_PUT;
    end else if (m_delete) begin
      verdict.kind = MATCH_DELETE;
    end else if (m_head) begin
      verdict.kind = MATCH_HEAD;
    end else if (seen_next < SeenW'(PrefixDepth)) begin
      verdict.reason = DROP_TRUNCATED;
    end else begin
      verdict.reason = DROP_NO_MATCH;
    end
    verdict.keep = (verdict.reason == DROP_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      ether_type <= '0;
      protocol   <= '0;
      ip_hdr     <= '0;
      total_len  <= '0;
      tcp_hdr    <= '0;
      seen       <= '0;
    end else if (advance) begin
      if (last_byte) begin
        pos        <= '0;
        ether_type <= '0;
        protocol   <= '0;
        ip_hdr     <= '0;
        total_len  <= '0;
        tcp_hdr    <= '0;
        seen       <= '0;
      end else begin
        pos        <= pos_next;
        ether_type <= ether_type_next;
        protocol   <= protocol_next;
        ip_hdr     <= ip_hdr_next;
        total_len  <= total_len_next;
        tcp_hdr    <= tcp_hdr_next;
        seen       <= seen_next;
      end
    end
  end

  // entries at or above the fill count are never compared
  always_ff @(posedge clk) begin
    if (advance && prefix_we) begin
      prefix[seen] <= data_byte;
    end
  end

endmodule

// ===== rtl/hpc_result_stage.sv =====
module hpc_result_stage import hpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  verdict_t   verdict,
  input  logic       out_stall,
  output logic       out_valid,
  output logic       keep,
  output logic [2:0] match_kind,
  output logic [2:0] drop_reason
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      keep        <= verdict.keep;
      match_kind  <= verdict.kind;
      drop_reason <= verdict.reason;
    end
  end

endmodule

// ===== rtl/http_packet_classifier_unit.sv =====
// Verdict path: the last byte enters the input register, then its verdict is loaded into the result register.
// Throughput: one byte per cycle, set by the single-pass parser stage between the
//   input register and the result register; a held result stalls input only on a last byte.
// Reset: synchronous rst clears the handshake state and the frame state and sets
//   min_payload_length to 7.
module http_packet_classifier_unit import hpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       keep,
  output logic [2:0] match_kind,
  output logic [2:0] drop_reason
);

  logic [7:0]  min_payload_length;
  stage_ctrl_t stage;
  logic [7:0]  stage_byte;
  logic        advance;
  logic        load;
  verdict_t    verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_payload_length <= MinPayloadReset;
    end else if (cfg_wr_en) begin
      min_payload_length <= cfg_wr_data;
    end
  end

  assign advance = stage.valid && (!stage.last || !out_valid || !out_stall);
  assign load    = advance && stage.last;

  hpc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .advance    (advance),
    .in_stall   (in_stall),
    .stage      (stage),
    .stage_byte (stage_byte)
  );

  hpc_frame_parser u_parser (
    .clk                (clk),
    .rst                (rst),
    .advance            (advance),
    .data_byte          (stage_byte),
    .last_byte          (stage.last),
    .min_payload_length (min_payload_length),
    .verdict            (verdict)
  );

  hpc_result_stage u_result (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .verdict     (verdict),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .keep        (keep),
    .match_kind  (match_kind),
    .drop_reason (drop_reason)
  );

  a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && stage.valid && stage.last))
    else $error("input stalled without a held result");

  a_result_from_last_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(stage.valid && stage.last))
    else $error("result without a last byte");

  a_keep_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((keep == (drop_reason == DROP_NONE)) && (keep || match_kind == MATCH_NONE)
                   && (!keep || match_kind != MATCH_NONE)))
    else $error("keep, match kind and drop reason disagree");

endmodule

// ===== bench/tb_http_packet_classifier_unit.sv =====
module tb_http_packet_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import hpc_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int HoldCycles = 400;
  localparam int MaxPrinted = 100;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'd0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       keep;
  logic [2:0] match_kind;
  logic [2:0] drop_reason;

  http_packet_classifier_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .keep        (keep),
    .match_kind  (match_kind),
    .drop_reason (drop_reason)
  );

  always #5 clk = ~clk;

  // frame tracker state, mirrors the parser
  logic [7:0]  min_len;
  logic [15:0] pos;
  logic [15:0] etype;
  logic [7:0]  proto;
  logic [5:0]  ihl;
  logic [15:0] tlen;
  logic [5:0]  thl;
  logic [2:0]  seen;
  logic [7:0]  prefix [PrefixDepth];
  verdict_t    expected_verdicts [$];

  logic [7:0] frame_q [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;

  int errors = 0;
  int cycle_count = 0;
  int bytes_accepted = 0;
  int verdicts_seen = 0;
  int kept_count = 0;
  int config_writes = 0;

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    if (errors <= MaxPrinted)
      $display("mismatch on %s of verdict %0d: got %0d, expected %0d",
               field, verdicts_seen, got, want);
  endtask

  task automatic clear_frame();
    pos = '0;
    etype = '0;
    proto = '0;
    ihl = '0;
    tlen = '0;
    thl = '0;
    seen = '0;
    for (int i = 0; i < PrefixDepth; i++) prefix[i] = 8'd0;
  endtask

  function automatic bit prefix_is(input string pat);
    if (seen < pat.len()) return 1'b0;
    for (int i = 0; i < pat.len(); i++)
      if (prefix[i] != pat[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic match_kind_t payload_kind();
    if (prefix_is("HTTP")) return MATCH_HTTP;
    if (prefix_is("GET")) return MATCH_GET;
    if (prefix_is("POST")) return MATCH_POST;
    if (prefix_is("PUT")) return MATCH_PUT;
    if (prefix_is("DELETE")) return MATCH_DELETE;
    if (prefix_is("HEAD")) return MATCH_HEAD;
    return MATCH_NONE;
  endfunction

  function automatic verdict_t classify(input int n);
    verdict_t v;
    int hdrs;
    match_kind_t k;
    v.keep = 1'b0;
    v.kind = MATCH_NONE;
    v.reason = DROP_NONE;
    hdrs = int'(ihl) + int'(thl);
    if (n < int'(EthHdrBytes)) v.reason = DROP_TRUNCATED;
    else if (etype != EtherTypeIpv4) v.reason = DROP_ETHERTYPE;
    else if (n < int'(IpMinFrame)) v.reason = DROP_TRUNCATED;
    else if (proto != ProtoTcp) v.reason = DROP_PROTOCOL;
    else if (ihl < MinHdrBytes) v.reason = DROP_SHORT_HEADER;
    else if (n < int'(TcpMinFrame) + int'(ihl)) v.reason = DROP_TRUNCATED;
    else if (thl < MinHdrBytes) v.reason = DROP_SHORT_HEADER;
    else if (int'(tlen) < hdrs) v.reason = DROP_SHORT_PAYLOAD;
    else if (int'(tlen) - hdrs < int'(min_len)) v.reason = DROP_SHORT_PAYLOAD;
    else begin
      k = payload_kind();
      if (k != MATCH_NONE) begin
        v.keep = 1'b1;
        v.kind = k;
      end else begin
        v.reason = (seen < PrefixDepth) ? DROP_TRUNCATED : DROP_NO_MATCH;
      end
    end
    return v;
  endfunction

  task automatic track_byte(input logic [7:0] b, input logic l);
    int p;
    int tcp_pos;
    int start;
    p = int'(pos);
    tcp_pos = int'(TcpOffsetPos) + int'(ihl);
    if (p == int'(EtypeHiPos)) etype = {b, 8'h00};
    else if (p == int'(EtypeLoPos)) etype[7:0] = b;
    else if (p == int'(IhlPos)) ihl = {b[3:0], 2'b00};
    else if (p == int'(TlenHiPos)) tlen = {b, 8'h00};
    else if (p == int'(TlenLoPos)) tlen[7:0] = b;
    else if (p == int'(ProtoPos)) proto = b;
    if (p >= int'(TcpOffsetPos) && p == tcp_pos) begin
      thl = {b[7:4], 2'b00};
    end else if (p > tcp_pos) begin
      start = int'(EthHdrBytes) + int'(ihl) + int'(thl);
      if (p >= start && p - start < PrefixDepth && seen < PrefixDepth) begin
        prefix[seen] = b;
        seen++;
      end
    end
    if (pos != PosMax) pos++;
    if (l) begin
      expected_verdicts.push_back(classify(int'(pos)));
      clear_frame();
    end
  endtask

  task automatic check_verdict();
    verdict_t want;
    if (expected_verdicts.size() == 0) begin
      report_mismatch("presence", 1, 0);
    end else begin
      want = expected_verdicts.pop_front();
      verdicts_seen++;
      if (keep === 1'b1) kept_count++;
      if (keep !== want.keep) report_mismatch("keep", int'(keep), int'(want.keep));
      if (match_kind !== want.kind)
        report_mismatch("match_kind", int'(match_kind), int'(want.kind));
      if (drop_reason !== want.reason)
        report_mismatch("drop_reason", int'(drop_reason), int'(want.reason));
    end
  endtask

  // transfers on both channels, config writes
  always @(posedge clk) begin
    if (rst) begin
      min_len = MinPayloadReset;
      clear_frame();
    end else begin
      if (out_valid && !out_stall) check_verdict();
      if (cfg_wr_en) min_len = cfg_wr_data;
      if (in_valid && !in_stall) begin
        bytes_accepted++;
        track_byte(data_byte, last_byte);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req) hold_left <= HoldCycles;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    out_stall <= hold_req || (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_min_len(input logic [7:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    config_writes++;
  endtask

  task automatic set_traffic(input int s, input int r);
    send_idle_pct = s;
    recv_stall_pct = r;
  endtask

  function automatic string method_text(input match_kind_t k);
    case (k)
      MATCH_HTTP:   return "HTTP";
      MATCH_GET:    return "GET";
      MATCH_POST:   return "POST";
      MATCH_PUT:    return "PUT";
      MATCH_DELETE: return "DELETE";
      MATCH_HEAD:   return "HEAD";
      default:      return "";
    endcase
  endfunction

  task automatic put_byte(input int idx, input logic [7:0] v);
    if (idx < frame_q.size()) frame_q[idx] = v;
  endtask

  task automatic build_frame(input int len, input logic [15:0] etype_v,
                             input logic [7:0] proto_v, input logic [3:0] ihl_n,
                             input logic [3:0] doff_n, input logic [15:0] tlen_v,
                             input match_kind_t kind_v, input bit spoil);
    string txt;
    int ip_bytes;
    int pay_at;
    frame_q.delete();
    for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom));
    ip_bytes = 4 * int'(ihl_n);
    pay_at = int'(EthHdrBytes) + ip_bytes + 4 * int'(doff_n);
    put_byte(int'(EtypeHiPos), etype_v[15:8]);
    put_byte(int'(EtypeLoPos), etype_v[7:0]);
    put_byte(int'(IhlPos), {4'($urandom), ihl_n});
    put_byte(int'(TlenHiPos), tlen_v[15:8]);
    put_byte(int'(TlenLoPos), tlen_v[7:0]);
    put_byte(int'(ProtoPos), proto_v);
    put_byte(int'(TcpOffsetPos) + ip_bytes, {doff_n, 4'($urandom)});
    txt = method_text(kind_v);
    for (int i = 0; i < txt.len(); i++) put_byte(pay_at + i, txt[i]);
    // flip case of the final letter: a near miss
    if (spoil && txt.len() != 0) put_byte(pay_at + txt.len() - 1, txt[txt.len() - 1] ^ 8'h20);
  endtask

  // minimal IPv4/TCP headers; cut_len > 0 ends the frame early
  task automatic send_tcp(input match_kind_t kind_v, input int pay, input int cut_len,
                          input bit spoil);
    int len;
    len = (cut_len > 0) ? cut_len : 54 + pay;
    build_frame(len, EtherTypeIpv4, ProtoTcp, 4'd5, 4'd5, 16'(40 + pay), kind_v, spoil);
    send_frame();
  endtask

  task automatic random_frame();
    logic [3:0]  ihl_n;
    logic [3:0]  doff_n;
    logic [15:0] etype_v;
    logic [15:0] tlen_v;
    logic [7:0]  proto_v;
    int hdr;
    int pay;
    int len;
    int pick;
    ihl_n = ($urandom_range(99) < 85) ? 4'd5 : 4'($urandom_range(15));
    doff_n = ($urandom_range(99) < 85) ? 4'd5 : 4'($urandom_range(15));
    etype_v = ($urandom_range(99) < 92) ? EtherTypeIpv4 : 16'($urandom);
    proto_v = ($urandom_range(99) < 92) ? ProtoTcp : 8'($urandom);
    hdr = 4 * (int'(ihl_n) + int'(doff_n));
    pay = $urandom_range(12);
    pick = $urandom_range(99);
    if (pick < 75) tlen_v = 16'(hdr + pay);
    else if (pick < 90) tlen_v = 16'(hdr + $urandom_range(300));
    else tlen_v = 16'($urandom);
    len = int'(EthHdrBytes) + hdr + pay;
    if ($urandom_range(99) < 25) len = $urandom_range(len, 1);
    build_frame(len, etype_v, proto_v, ihl_n, doff_n, tlen_v,
                match_kind_t'($urandom_range(6)), $urandom_range(99) < 15);
    send_frame();
  endtask

  task automatic test_directed_frames();
    set_traffic(0, 0);
    send_tcp(MATCH_HTTP, 7, 58, 1'b0);
    send_tcp(MATCH_DELETE, 7, 60, 1'b0);
    send_tcp(MATCH_HEAD, 7, 60, 1'b1);
    send_tcp(MATCH_DELETE, 8, 58, 1'b0);
    build_frame(14, 16'h86DD, ProtoTcp, 4'd5, 4'd5, 16'd48, MATCH_GET, 1'b0);
    send_frame();
    build_frame(24, EtherTypeIpv4, 8'd17, 4'd5, 4'd5, 16'd48, MATCH_GET, 1'b0);
    send_frame();
    build_frame(24, EtherTypeIpv4, ProtoTcp, 4'd4, 4'd5, 16'd44, MATCH_GET, 1'b0);
    send_frame();
    build_frame(47, EtherTypeIpv4, ProtoTcp, 4'd5, 4'd4, 16'd48, MATCH_GET, 1'b0);
    send_frame();
    build_frame(47, EtherTypeIpv4, ProtoTcp, 4'd5, 4'd5, 16'd30, MATCH_GET, 1'b0);
    send_frame();
    send_tcp(MATCH_GET, 8, 20, 1'b0);
    send_tcp(MATCH_NONE, 0, 1, 1'b0);
    wait_idle();
  endtask

  task automatic test_payload_limits();
    set_traffic(0, 0);
    write_min_len(8'd0);
    send_tcp(MATCH_PUT, 3, 0, 1'b0);
    write_min_len(8'd255);
    build_frame(58, EtherTypeIpv4, ProtoTcp, 4'd5, 4'd5, 16'd295, MATCH_POST, 1'b0);
    send_frame();
    build_frame(47, EtherTypeIpv4, ProtoTcp, 4'd5, 4'd5, 16'd294, MATCH_GET, 1'b0);
    send_frame();
    build_frame(57, EtherTypeIpv4, ProtoTcp, 4'd5, 4'd5, 16'hFFFF, MATCH_GET, 1'b0);
    send_frame();
    write_min_len(MinPayloadReset);
    send_tcp(MATCH_HEAD, 7, 58, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int start_bytes;
    int start_frames;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_traffic(0, 0);
        1: set_traffic(54, 0);
        2: set_traffic(0, 54);
        default: set_traffic(11, 11);
      endcase
      write_min_len(($urandom_range(99) < 70) ? 8'($urandom_range(12)) : 8'($urandom));
      start_bytes = bytes_accepted;
      start_frames = verdicts_seen + expected_verdicts.size();
      while (bytes_accepted - start_bytes < 30 ||
             verdicts_seen + expected_verdicts.size() - start_frames < 2)
        random_frame();
      wait_idle();
    end
  endtask

  // receiver holds off while one-byte frames keep coming, so the input backs up
  task automatic test_backpressure();
    set_traffic(0, 0);
    wait_idle();
    fork
      begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      begin
        repeat (30) send_byte(8'($urandom), 1'b1);
      end
    join
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_payload_limits();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    $display("Checked %0d verdicts (%0d kept, %0d dropped) over %0d bytes, %0d register writes",
             verdicts_seen, kept_count, verdicts_seen - kept_count, bytes_accepted,
             config_writes);
    $display("Directed drop reasons and methods, payload limits, four idle mixes, long hold-off");
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hpc_pkg.sv
rtl/hpc_in_stage.sv
rtl/hpc_frame_parser.sv
rtl/hpc_result_stage.sv
rtl/http_packet_classifier_unit.sv
bench/tb_http_packet_classifier_unit.sv
